### rtl/core/amix_pkg.sv
// ----------------------------------------------------------------------------
// amix_pkg: shared types and constants for the audio mix playback FIFO
// Holds depths, function codes, mode codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package amix_pkg;

   localparam int RING_DEPTH = 4096;
   localparam int MIX_DEPTH  = 1024;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int MIX_AW     = $clog2(MIX_DEPTH);
   localparam int FILL_W     = RING_AW + 1;
   localparam int MIXLEN_W   = MIX_AW + 1;
   localparam int SAMPLE_W   = 16;
   localparam int DIV_W      = 8;

   typedef enum logic [1:0] {
      FUNC_BEGIN  = 2'd0,
      FUNC_MIX    = 2'd1,
      FUNC_COMMIT = 2'd2,
      FUNC_PULL   = 2'd3
   } func_type;

   localparam logic [1:0] MODE_AUTO   = 2'd0;
   localparam logic [1:0] MODE_PRESET = 2'd1;
   localparam logic [1:0] MODE_SILENT = 2'd2;
   localparam logic [1:0] MODE_RSVD   = 2'd3;

   localparam logic [1:0] CSR_MIX_MODE = 2'd0;
   localparam logic [1:0] CSR_PRESET   = 2'd1;
   localparam logic [1:0] CSR_MUTE     = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture the request
      logic clr_step;    // clear one mix entry (sweep)
      logic clr_start;   // start clear sweep
      logic div_start;   // start the divider
      logic mix_wr;      // write back mixed entry
      logic mix_fin;     // advance position / end of loop, no store write
      logic cp_start;    // start commit copy
      logic cp_step;     // one copy step
      logic cp_fin;      // finish commit
      logic pull_fin;    // finish pull
      logic begin_fin;   // finish begin frame
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      func_type func;
      logic     clr_done;
      logic     div_done;
      logic     mix_ok;     // position below depth
      logic     mix_add;    // mode adds (or mute writes)
      logic     cp_fits;
      logic     cp_done;
      logic     ring_empty;
   } sts_type;

endpackage

### rtl/core/amix_if.sv
// ----------------------------------------------------------------------------
// amix_req_if / amix_rsp_if: valid/ready channels of the mix FIFO
// Request carries one command, response one result.
// ----------------------------------------------------------------------------
interface amix_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [15:0] sample_in;
   logic        last_in_loop;
   logic [7:0]  loop_count;
   modport source (output valid, func, sample_in, last_in_loop, loop_count, input ready);
   modport sink   (input valid, func, sample_in, last_in_loop, loop_count, output ready);
endinterface

interface amix_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] sample_out;
   logic        underrun;
   logic [12:0] free_space;
   logic        pushed;
   logic [10:0] mix_length;
   modport source (output valid, sample_out, underrun, free_space, pushed, mix_length,
                   input ready);
   modport sink   (input valid, sample_out, underrun, free_space, pushed, mix_length,
                   output ready);
endinterface

### rtl/core/audio_mix_playback_fifo.sv
// ----------------------------------------------------------------------------
// audio_mix_playback_fifo: loop mixer feeding a playback ring FIFO
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// One command at a time. A mix sample that adds or mutes passes through
// decode, the serial divider, write-back and response; one that adds nothing
// or lands past the mix store goes from decode straight to response. Begin
// frame runs the mix store clearing sweep; a commit that fits copies one
// sample per cycle over the single RAM ports, and a refused commit copies
// nothing. After reset the mix store is cleared before the first transfer
// is taken. Each result is held until taken, so a receiver stall holds the
// block in its response state.
module audio_mix_playback_fifo
   import amix_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   amix_req_if.sink   req,
   amix_rsp_if.source rsp,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);
   ctl_type ctl;
   sts_type sts;

   amix_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .ctl       (ctl),
      .sts       (sts)
   );

   amix_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .sts              (sts),
      .req_func         (req.func),
      .req_sample_in    (req.sample_in),
      .req_last_in_loop (req.last_in_loop),
      .req_loop_count   (req.loop_count),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_sample_out   (rsp.sample_out),
      .rsp_underrun     (rsp.underrun),
      .rsp_free_space   (rsp.free_space),
      .rsp_pushed       (rsp.pushed),
      .rsp_mix_length   (rsp.mix_length)
   );
endmodule

### rtl/core/amix_ram.sv
// ----------------------------------------------------------------------------
// amix_ram: generic single-port RAM with registered read
// One write or one read per cycle.
// ----------------------------------------------------------------------------
module amix_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule

### rtl/core/amix_div.sv
// ----------------------------------------------------------------------------
// amix_div: signed 16 by unsigned 8 restoring divider
// One quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module amix_div
   import amix_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SAMPLE_W-1:0] dividend,
   input  logic [DIV_W-1:0]    divisor,
   output logic                done,
   output logic [SAMPLE_W-1:0] quotient
);
   localparam int CNT_W = $clog2(SAMPLE_W + 1);

   logic [SAMPLE_W-1:0] q_ff, q_in;
   logic [DIV_W:0]      rem_ff, rem_in;
   logic [DIV_W-1:0]    d_ff, d_in;
   logic                neg_ff, neg_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [DIV_W:0]      trial;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[DIV_W-1:0], q_ff[SAMPLE_W-1]};
      if (start) begin
         neg_in  = dividend[SAMPLE_W-1];
         q_in    = dividend[SAMPLE_W-1] ? (~dividend + 1'b1) : dividend;
         rem_in  = '0;
         d_in    = (divisor == '0) ? DIV_W'(1) : divisor;
         cnt_in  = CNT_W'(SAMPLE_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            rem_in = trial - {1'b0, d_ff};
            q_in   = {q_ff[SAMPLE_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[SAMPLE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
   end

   // high in the last step; the quotient is valid from the next cycle
   assign done     = busy_ff && (cnt_ff == CNT_W'(1));
   assign quotient = neg_ff ? (~q_ff + 1'b1) : q_ff;
endmodule

### rtl/core/amix_datapath.sv
// ----------------------------------------------------------------------------
// amix_datapath: mix store, ring FIFO, pointers and result register
// Driven step by step by the controller.
// ----------------------------------------------------------------------------
module amix_datapath
   import amix_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctl_type             ctl,
   output sts_type             sts,
   input  logic [1:0]          req_func,
   input  logic [15:0]         req_sample_in,
   input  logic                req_last_in_loop,
   input  logic [7:0]          req_loop_count,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_data,
   output logic [15:0]         rsp_sample_out,
   output logic                rsp_underrun,
   output logic [12:0]         rsp_free_space,
   output logic                rsp_pushed,
   output logic [10:0]         rsp_mix_length
);
   logic [1:0]          mode_ff;
   logic [DIV_W-1:0]    preset_ff;
   logic                mute_ff;
   logic [1:0]          func_ff;
   logic [15:0]         smp_ff;
   logic                last_ff;
   logic [7:0]          cnt_ff;
   logic [MIXLEN_W-1:0] pos_ff, pos_in;
   logic [MIXLEN_W-1:0] run_ff, run_in;
   logic [RING_AW-1:0]  wp_ff, rp_ff;
   logic [FILL_W-1:0]   fill_ff;
   logic                empty_ff;
   logic [MIXLEN_W-1:0] idx_ff;     // clear / copy index
   logic                copy_vld_ff;
   logic [15:0]         out_smp_ff;
   logic                out_und_ff, out_push_ff;
   logic [12:0]         out_free_ff;

   logic                mix_we;
   logic [MIX_AW-1:0]   mix_addr;
   logic [15:0]         mix_wdata, mix_rdata;
   logic                ring_we;
   logic [RING_AW-1:0]  ring_addr;
   logic [15:0]         ring_rdata;
   logic                div_done;
   logic [15:0]         quot;
   logic [DIV_W-1:0]    divisor;
   logic [FILL_W-1:0]   free_w;
   logic [RING_AW-1:0]  wp_nx;

   assign divisor = (mode_ff == MODE_AUTO) ? cnt_ff : preset_ff;
   assign free_w  = FILL_W'(RING_DEPTH) - fill_ff;

   amix_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.div_start),
      .dividend (smp_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quot)
   );

   // mix store: clear sweep, read-modify-write at position, copy read
   always_comb begin
      mix_we    = 1'b0;
      mix_wdata = '0;
      mix_addr  = pos_ff[MIX_AW-1:0];
      if (ctl.clr_step) begin
         mix_we   = 1'b1;
         mix_addr = idx_ff[MIX_AW-1:0];
      end else if (ctl.cp_step || ctl.cp_start) begin
         mix_addr = ctl.cp_start ? '0 : idx_ff[MIX_AW-1:0] + 1'b1;
      end else if (ctl.mix_wr) begin
         mix_we    = 1'b1;
         mix_wdata = mute_ff ? '0 : mix_rdata + quot;
      end
   end

   amix_ram #(.WIDTH(16), .DEPTH(MIX_DEPTH)) u_mix (
      .clock (clock), .we (mix_we), .addr (mix_addr),
      .wdata (mix_wdata), .rdata (mix_rdata)
   );

   assign wp_nx     = (wp_ff == RING_AW'(RING_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign ring_we   = ctl.cp_step && copy_vld_ff;
   assign ring_addr = ring_we ? wp_ff : rp_ff;

   amix_ram #(.WIDTH(16), .DEPTH(RING_DEPTH)) u_ring (
      .clock (clock), .we (ring_we), .addr (ring_addr),
      .wdata (mix_rdata), .rdata (ring_rdata)
   );

   always_comb begin
      pos_in = pos_ff;
      run_in = run_ff;
      if (ctl.mix_fin) begin
         if (pos_ff < MIXLEN_W'(MIX_DEPTH)) begin
            pos_in = pos_ff + 1'b1;
         end
         if (last_ff) begin
            if (pos_in > run_ff) begin
               run_in = pos_in;
            end
            pos_in = '0;
         end
      end else if (ctl.begin_fin) begin
         pos_in = '0;
         run_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_AUTO;
         preset_ff   <= DIV_W'(1);
         mute_ff     <= 1'b0;
         pos_ff      <= '0;
         run_ff      <= '0;
         wp_ff       <= '0;
         rp_ff       <= '0;
         fill_ff     <= '0;
         empty_ff    <= 1'b0;
         idx_ff      <= '0;
         copy_vld_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_MIX_MODE: mode_ff   <= csr_data[1:0];
               CSR_PRESET:   preset_ff <= csr_data;
               CSR_MUTE:     mute_ff   <= csr_data[0];
               default:      ;
            endcase
         end
         pos_ff <= pos_in;
         run_ff <= run_in;
         if (ctl.clr_start) begin
            idx_ff <= '0;
         end else if (ctl.clr_step) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (ctl.cp_start) begin
            idx_ff      <= '0;
            copy_vld_ff <= 1'b1;
         end else if (ctl.cp_step) begin
            idx_ff <= idx_ff + 1'b1;
            if (copy_vld_ff) begin
               wp_ff <= wp_nx;
            end
         end
         if (ctl.cp_fin && sts.cp_fits) begin
            fill_ff <= fill_ff + FILL_W'(run_ff);
         end
         if (ctl.pull_fin) begin
            if (fill_ff == '0) begin
               empty_ff <= 1'b1;
            end else begin
               rp_ff    <= (rp_ff == RING_AW'(RING_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
               fill_ff  <= fill_ff - 1'b1;
               empty_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         func_ff <= req_func;
         smp_ff  <= req_sample_in;
         last_ff <= req_last_in_loop;
         cnt_ff  <= req_loop_count;
      end
      if (ctl.load) begin
         out_smp_ff  <= '0;
         out_und_ff  <= 1'b0;
         out_free_ff <= '0;
         out_push_ff <= 1'b0;
      end else if (ctl.begin_fin) begin
         out_free_ff <= 13'(free_w);
      end else if (ctl.cp_fin) begin
         out_push_ff <= sts.cp_fits;
      end else if (ctl.pull_fin) begin
         out_und_ff <= (fill_ff == '0);
         out_smp_ff <= (fill_ff == '0) ? '0 : ring_rdata;
      end
   end

   assign sts.func       = func_type'(func_ff);
   assign sts.clr_done   = (idx_ff == MIXLEN_W'(MIX_DEPTH - 1));
   assign sts.div_done   = div_done;
   assign sts.mix_ok     = (pos_ff < MIXLEN_W'(MIX_DEPTH));
   assign sts.mix_add    = mute_ff || (mode_ff == MODE_AUTO) || (mode_ff == MODE_PRESET);
   assign sts.cp_fits    = ({2'b0, run_ff} <= free_w);
   assign sts.cp_done    = (idx_ff >= run_ff) || !sts.cp_fits;
   assign sts.ring_empty = empty_ff;

   assign rsp_sample_out = out_smp_ff;
   assign rsp_underrun   = out_und_ff;
   assign rsp_free_space = out_free_ff;
   assign rsp_pushed     = out_push_ff;
   assign rsp_mix_length = run_ff;
endmodule

### rtl/core/amix_ctrl.sv
// ----------------------------------------------------------------------------
// amix_ctrl: sequencer for the mix FIFO
// Walks each command through its datapath steps and holds the response.
// ----------------------------------------------------------------------------
module amix_ctrl
   import amix_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output ctl_type ctl,
   input  sts_type sts
);
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b0_0000_0001,
      ST_DECODE = 9'b0_0000_0010,
      ST_CLEAR  = 9'b0_0000_0100,
      ST_DIV    = 9'b0_0000_1000,
      ST_MIXWR  = 9'b0_0001_0000,
      ST_COPY   = 9'b0_0010_0000,
      ST_PULL   = 9'b0_0100_0000,
      ST_RESP   = 9'b0_1000_0000,
      ST_INIT   = 9'b1_0000_0000
   } state_type;

   state_type        state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         // mix store sweep after reset, no response
         ST_INIT: begin
            ctl.clr_step = 1'b1;
            if (sts.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (sts.func)
               FUNC_BEGIN: begin
                  ctl.clr_start = 1'b1;
                  state_in      = ST_CLEAR;
               end
               FUNC_MIX: begin
                  if (sts.mix_ok && sts.mix_add) begin
                     ctl.div_start = 1'b1;
                     state_in      = ST_DIV;
                  end else begin
                     ctl.mix_fin = 1'b1;
                     state_in    = ST_RESP;
                  end
               end
               FUNC_COMMIT: begin
                  ctl.cp_start = 1'b1;
                  state_in     = ST_COPY;
               end
               FUNC_PULL: begin
                  state_in = ST_PULL;
               end
               default: state_in = ST_RESP;
            endcase
         end
         ST_CLEAR: begin
            ctl.clr_step = 1'b1;
            if (sts.clr_done) begin
               ctl.begin_fin = 1'b1;
               state_in      = ST_RESP;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_MIXWR;
            end
         end
         ST_MIXWR: begin
            ctl.mix_wr  = 1'b1;
            ctl.mix_fin = 1'b1;
            state_in    = ST_RESP;
         end
         ST_COPY: begin
            if (sts.cp_done) begin
               ctl.cp_fin = 1'b1;
               state_in   = ST_RESP;
            end else begin
               ctl.cp_step = 1'b1;
            end
         end
         ST_PULL: begin
            ctl.pull_fin = 1'b1;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_one_hot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while response pending");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> (state_ff == ST_DECODE)) else $error("load did not decode");
`endif
endmodule

### sim/audio_mix_playback_fifo_test.sv
// ----------------------------------------------------------------------------
// audio_mix_playback_fifo_test: self-checking bench for the loop mixer FIFO
// Drives begin/mix/commit/pull commands over valid/ready, predicts every
// result from a behavioral copy of the mix store and ring FIFO, and checks
// each response field by field under several config and idling phases.
// ----------------------------------------------------------------------------
module audio_mix_playback_fifo_test;
   import amix_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic [15:0] sample_out;
      logic        underrun;
      logic [12:0] free_space;
      logic        pushed;
      logic [10:0] mix_length;
   } mix_result_type;

   logic       clock;
   logic       reset;
   logic       csr_write;
   logic [1:0] csr_index;
   logic [7:0] csr_data;

   amix_req_if req ();
   amix_rsp_if rsp ();

   audio_mix_playback_fifo DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req.sink),
      .rsp       (rsp.source),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // behavioral copy of the block state
   logic [15:0] mix_acc [MIX_DEPTH];
   logic [15:0] ring_mem [RING_DEPTH];
   int          mix_pos;
   int          run_len;
   int          wr_ptr;
   int          rd_ptr;
   int          fill_cnt;
   logic [1:0]  cfg_mode;
   logic [7:0]  cfg_divisor;
   logic        cfg_mute;

   mix_result_type expected_q [$];

   int errors;
   int cycles;
   int items_sent;
   int results_seen;
   int underruns_seen;
   int commits_dropped;
   int send_idle_pct;
   int rsp_stall_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still outstanding", $time, expected_q.size());
         $display("FAILURE");
         $finish;
      end
   end

   function automatic mix_result_type predict_mix(logic [1:0] func, logic [15:0] sample,
                                                  logic last, logic [7:0] count);
      mix_result_type r;
      int s;
      int d;
      int q;
      r = '0;
      case (func_type'(func))
         FUNC_BEGIN: begin
            for (int i = 0; i < MIX_DEPTH; i++) mix_acc[i] = '0;
            mix_pos = 0;
            run_len = 0;
            r.free_space = 13'(RING_DEPTH - fill_cnt);
         end
         FUNC_MIX: begin
            if (mix_pos < MIX_DEPTH) begin
               s = $signed(sample);
               if (cfg_mute) begin
                  mix_acc[mix_pos] = '0;
               end else if (cfg_mode == MODE_AUTO || cfg_mode == MODE_PRESET) begin
                  d = (cfg_mode == MODE_AUTO) ? int'(count) : int'(cfg_divisor);
                  if (d == 0) d = 1;
                  q = s / d;   // truncates toward zero
                  mix_acc[mix_pos] = mix_acc[mix_pos] + q[15:0];
               end
               mix_pos++;
            end
            if (last) begin
               if (mix_pos > run_len) run_len = mix_pos;
               mix_pos = 0;
            end
         end
         FUNC_COMMIT: begin
            if (run_len <= RING_DEPTH - fill_cnt) begin
               for (int i = 0; i < run_len; i++) begin
                  ring_mem[wr_ptr] = mix_acc[i];
                  wr_ptr = (wr_ptr + 1) % RING_DEPTH;
               end
               fill_cnt += run_len;
               r.pushed = 1'b1;
            end else begin
               commits_dropped++;
            end
         end
         default: begin
            if (fill_cnt == 0) begin
               r.underrun = 1'b1;
            end else begin
               r.sample_out = ring_mem[rd_ptr];
               rd_ptr = (rd_ptr + 1) % RING_DEPTH;
               fill_cnt--;
            end
         end
      endcase
      r.mix_length = run_len[10:0];
      return r;
   endfunction

   // one command transfer; prediction is taken at the accepting edge
   task automatic send_item(logic [1:0] func, logic [15:0] sample, logic last,
                            logic [7:0] count);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid        <= 1'b1;
      req.func         <= func;
      req.sample_in    <= sample;
      req.last_in_loop <= last;
      req.loop_count   <= count;
      do @(posedge clock); while (!req.ready);
      expected_q.insert(expected_q.size(), predict_mix(func, sample, last, count));
      items_sent++;
   endtask

   always @(posedge clock) begin
      mix_result_type want;
      mix_result_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got = {rsp.sample_out, rsp.underrun, rsp.free_space, rsp.pushed, rsp.mix_length};
         results_seen++;
         if (got.underrun) underruns_seen++;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (got.sample_out !== want.sample_out) begin
               $display("%0t: sample_out exp %h got %h", $time, want.sample_out,
                        got.sample_out);
               errors++;
            end
            if (got.underrun !== want.underrun) begin
               $display("%0t: underrun exp %b got %b", $time, want.underrun, got.underrun);
               errors++;
            end
            if (got.free_space !== want.free_space) begin
               $display("%0t: free_space exp %0d got %0d", $time, want.free_space,
                        got.free_space);
               errors++;
            end
            if (got.pushed !== want.pushed) begin
               $display("%0t: pushed exp %b got %b", $time, want.pushed, got.pushed);
               errors++;
            end
            if (got.mix_length !== want.mix_length) begin
               $display("%0t: mix_length exp %0d got %0d", $time, want.mix_length,
                        got.mix_length);
               errors++;
            end
         end
      end
   end

   task automatic wait_drained();
      @(negedge clock);
      req.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // config writes only while the block is idle
   task automatic write_csr(logic [1:0] index, logic [7:0] data);
      wait_drained();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      case (index)
         CSR_MIX_MODE: cfg_mode    = data[1:0];
         CSR_PRESET:   cfg_divisor = data;
         CSR_MUTE:     cfg_mute    = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic test_directed();
      send_item(FUNC_PULL, 16'h0000, 1'b0, 8'd0);          // pull from empty FIFO
      send_item(FUNC_BEGIN, 16'hffff, 1'b1, 8'hff);
      send_item(FUNC_MIX, 16'h8000, 1'b0, 8'd0);           // zero loop count
      send_item(FUNC_MIX, 16'h7fff, 1'b0, 8'd255);
      send_item(FUNC_MIX, 16'hffff, 1'b1, 8'd3);           // -1/3 truncates to 0
      send_item(FUNC_MIX, 16'h7fff, 1'b0, 8'd1);
      send_item(FUNC_MIX, 16'h8001, 1'b1, 8'd2);           // shorter loop keeps length
      send_item(FUNC_COMMIT, 16'h0, 1'b0, 8'd0);
      send_item(FUNC_PULL, 16'h0, 1'b0, 8'd0);
      send_item(FUNC_PULL, 16'h0, 1'b0, 8'd0);
      write_csr(CSR_MIX_MODE, 8'(MODE_PRESET));
      write_csr(CSR_PRESET, 8'd0);                        // clamped to one
      send_item(FUNC_BEGIN, 16'h0, 1'b0, 8'd0);
      send_item(FUNC_MIX, 16'h8000, 1'b0, 8'd7);
      send_item(FUNC_COMMIT, 16'h0, 1'b0, 8'd0);           // empty mix always fits
      write_csr(CSR_PRESET, 8'd255);
      send_item(FUNC_MIX, 16'h8000, 1'b1, 8'd7);
      write_csr(CSR_MIX_MODE, 8'(MODE_SILENT));
      send_item(FUNC_MIX, 16'h1234, 1'b1, 8'd1);
      write_csr(CSR_MIX_MODE, 8'(MODE_RSVD));
      send_item(FUNC_MIX, 16'h4321, 1'b1, 8'd1);
      write_csr(CSR_MUTE, 8'd1);
      send_item(FUNC_MIX, 16'h7fff, 1'b1, 8'd1);
      send_item(FUNC_COMMIT, 16'h0, 1'b0, 8'd0);
      send_item(FUNC_PULL, 16'h0, 1'b0, 8'd0);
      send_item(FUNC_PULL, 16'h0, 1'b0, 8'd0);
      send_item(FUNC_PULL, 16'h0, 1'b0, 8'd0);
      send_item(FUNC_PULL, 16'h0, 1'b0, 8'd0);
      write_csr(CSR_MUTE, 8'd0);
      write_csr(CSR_MIX_MODE, 8'(MODE_AUTO));
   endtask

   // begin, a few loops of random samples, commit, then some pulls
   task automatic random_frame();
      int nloops;
      int len;
      logic [7:0] count;
      nloops = $urandom_range(1, 4);
      count  = ($urandom_range(1) == 0) ? 8'($urandom_range(0, 4)) : 8'($urandom);
      send_item(FUNC_BEGIN, 16'($urandom), 1'($urandom), 8'($urandom));
      for (int l = 0; l < nloops; l++) begin
         len = $urandom_range(1, 30);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 4)
               send_item(2'($urandom_range(1, 3)), 16'($urandom), 1'($urandom),
                         8'($urandom));
            send_item(FUNC_MIX, 16'($urandom), (i == len - 1), count);
         end
      end
      if ($urandom_range(9) == 0) wait_drained();
      send_item(FUNC_COMMIT, 16'($urandom), 1'($urandom), 8'($urandom));
      if ($urandom_range(3) == 0) send_item(FUNC_COMMIT, 16'h0, 1'b0, 8'd0);
      len = $urandom_range(0, 60);
      for (int i = 0; i < len; i++)
         send_item(FUNC_PULL, 16'($urandom), 1'($urandom), 8'($urandom));
   endtask

   task automatic test_random_phase(int idle_pct, int stall_pct, int budget);
      int stop_at;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      write_csr(CSR_MIX_MODE, 8'($urandom_range(0, 3)));
      write_csr(CSR_PRESET, ($urandom_range(3) == 0) ? 8'd255 : 8'($urandom_range(0, 9)));
      write_csr(CSR_MUTE, 8'($urandom_range(7) == 0));
      stop_at = items_sent + budget;
      while (items_sent < stop_at) random_frame();
   endtask

   // one maximal loop past the store depth, then commit until the FIFO refuses
   task automatic test_fill_ring();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_csr(CSR_MUTE, 8'd0);
      write_csr(CSR_MIX_MODE, 8'(MODE_AUTO));
      send_item(FUNC_BEGIN, 16'h0, 1'b0, 8'd0);
      for (int i = 0; i < MIX_DEPTH + 6; i++)
         send_item(FUNC_MIX, 16'($urandom), (i == MIX_DEPTH + 5), 8'($urandom_range(0, 2)));
      for (int i = 0; i < 6; i++) send_item(FUNC_COMMIT, 16'h0, 1'b0, 8'd0);
      send_item(FUNC_BEGIN, 16'h0, 1'b0, 8'd0);
      for (int i = 0; i < 20; i++) send_item(FUNC_PULL, 16'h0, 1'b0, 8'd0);
   endtask

   initial begin
      errors = 0; cycles = 0; items_sent = 0; results_seen = 0;
      underruns_seen = 0; commits_dropped = 0;
      send_idle_pct = 0; rsp_stall_pct = 0;
      for (int i = 0; i < MIX_DEPTH; i++) mix_acc[i] = '0;
      mix_pos = 0; run_len = 0; wr_ptr = 0; rd_ptr = 0; fill_cnt = 0;
      cfg_mode = MODE_AUTO; cfg_divisor = 8'd1; cfg_mute = 1'b0;
      req.valid = 1'b0; req.func = FUNC_BEGIN; req.sample_in = '0;
      req.last_in_loop = 1'b0; req.loop_count = '0;
      csr_write = 1'b0; csr_index = CSR_MIX_MODE; csr_data = '0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_phase(0, 0, 110);
      test_random_phase(68, 0, 110);
      test_random_phase(0, 68, 110);
      test_random_phase(22, 22, 110);
      test_fill_ring();

      wait_drained();
      repeat (40) @(posedge clock);
      $display("Covered %0d commands, %0d responses: %0d underruns, %0d commits refused.",
               items_sent, results_seen, underruns_seen, commits_dropped);
      $display("Modes auto/preset/none/undefined, mute, divisor extremes, full mix store.");
      if (errors == 0 && expected_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/amix_pkg.sv
rtl/core/amix_if.sv
rtl/core/amix_ram.sv
rtl/core/amix_div.sv
rtl/core/amix_datapath.sv
rtl/core/amix_ctrl.sv
rtl/core/audio_mix_playback_fifo.sv
sim/audio_mix_playback_fifo_test.sv
